// ===== rtl/lsw_pkg.sv =====
// Shared types and constants of the lidar scan to world point transform.
// Depends on nothing; the register block, the CORDIC stage, the top level and the testbench import it.
package lsw_pkg;

  localparam int unsigned RANGE_W = 16;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned POS_W = 24;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // CORDIC datapath widths. The rotated vector stays below 2^33 in magnitude.
  localparam int unsigned XY_W = 36;
  localparam int unsigned T_W = 33;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned RND_W = XY_W - FRAC_W;
  localparam int unsigned SUM_W = POS_W + 1;

  localparam logic [15:0] GAIN_Q16 = 16'd39797;

  localparam int unsigned CORDIC_ITERS = 24;
  localparam int unsigned ITERS_PER_STAGE = 2;
  localparam int unsigned CRD_STAGES = CORDIC_ITERS / ITERS_PER_STAGE;

  // atan(2^-i) as a binary angle, a full turn being 2^32.
  localparam logic [29:0] ATAN_TAB [CORDIC_ITERS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331, 30'd21354465, 30'd10680862, 30'd5340245,
    30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
    30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81
  };

  typedef enum logic [2:0] {
    REG_START_ANGLE  = 3'd0,
    REG_ANGLE_STEP   = 3'd1,
    REG_MIN_RANGE    = 3'd2,
    REG_MAX_RANGE    = 3'd3,
    REG_POSE_X       = 3'd4,
    REG_POSE_Y       = 3'd5,
    REG_POSE_HEADING = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [ANGLE_W-1:0]        angle_step;
    logic [ANGLE_W-1:0]        angle_base;
    logic [RANGE_W-1:0]        min_range_mm;
    logic [RANGE_W-1:0]        max_range_mm;
    logic signed [POS_W-1:0]   pose_x_mm;
    logic signed [POS_W-1:0]   pose_y_mm;
  } cfg_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [T_W-1:0]  t;
  } crd_t;

endpackage

// ===== rtl/lsw_if.sv =====
// Stream channel interfaces of the lidar point transform: readings in, points out.
// Each carries valid, ready and the item fields; no package dependency.
interface lsw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        range_finite;
  logic [15:0] sample_index;

  modport source (output valid, output range_mm, output range_finite,
                  output sample_index, input ready);
  modport sink (input valid, input range_mm, input range_finite,
                input sample_index, output ready);
endinterface

interface lsw_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] world_x_mm;
  logic signed [23:0] world_y_mm;

  modport source (output valid, output world_x_mm, output world_y_mm, input ready);
  modport sink (input valid, input world_x_mm, input world_y_mm, output ready);
endinterface

// ===== rtl/lsw_apb_regs.sv =====
// APB configuration registers of the lidar point transform.
// Depends on lsw_pkg for the register index codes and the cfg_t bundle.
module lsw_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsw_pkg::APB_AW-1:0] paddr,
  input  logic [lsw_pkg::APB_DW-1:0] pwdata,
  output logic [lsw_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output lsw_pkg::cfg_t              cfg_o
);
  import lsw_pkg::*;

  logic [ANGLE_W-1:0] start_angle_q;
  logic [ANGLE_W-1:0] angle_step_q;
  logic [RANGE_W-1:0] min_range_q;
  logic [RANGE_W-1:0] max_range_q;
  logic [POS_W-1:0]   pose_x_q;
  logic [POS_W-1:0]   pose_y_q;
  logic [ANGLE_W-1:0] heading_q;
  logic [ANGLE_W-1:0] angle_base_q;
  logic [ANGLE_W-1:0] angle_base_d;
  logic               wr_en;
  reg_idx_e           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_angle_q <= '0;
      angle_step_q  <= '0;
      min_range_q   <= '0;
      max_range_q   <= '1;
      pose_x_q      <= '0;
      pose_y_q      <= '0;
      heading_q     <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_START_ANGLE:  start_angle_q <= pwdata[ANGLE_W-1:0];
        REG_ANGLE_STEP:   angle_step_q  <= pwdata[ANGLE_W-1:0];
        REG_MIN_RANGE:    min_range_q   <= pwdata[RANGE_W-1:0];
        REG_MAX_RANGE:    max_range_q   <= pwdata[RANGE_W-1:0];
        REG_POSE_X:       pose_x_q      <= pwdata[POS_W-1:0];
        REG_POSE_Y:       pose_y_q      <= pwdata[POS_W-1:0];
        REG_POSE_HEADING: heading_q     <= pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // The constant part of the beam angle, including the half turn that flips
  // the beam direction, is folded into one register.
  assign angle_base_d = (start_angle_q + heading_q) ^ {1'b1, {(ANGLE_W-1){1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_base_q <= {1'b1, {(ANGLE_W-1){1'b0}}};
    end else begin
      angle_base_q <= angle_base_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_START_ANGLE:  prdata = APB_DW'(start_angle_q);
      REG_ANGLE_STEP:   prdata = APB_DW'(angle_step_q);
      REG_MIN_RANGE:    prdata = APB_DW'(min_range_q);
      REG_MAX_RANGE:    prdata = APB_DW'(max_range_q);
      REG_POSE_X:       prdata = APB_DW'(pose_x_q);
      REG_POSE_Y:       prdata = APB_DW'(pose_y_q);
      REG_POSE_HEADING: prdata = APB_DW'(heading_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.angle_step   = angle_step_q;
  assign cfg_o.angle_base   = angle_base_q;
  assign cfg_o.min_range_mm = min_range_q;
  assign cfg_o.max_range_mm = max_range_q;
  assign cfg_o.pose_x_mm    = $signed(pose_x_q);
  assign cfg_o.pose_y_mm    = $signed(pose_y_q);

endmodule

// ===== rtl/lsw_cordic_stage.sv =====
// One registered stage of the rotation-mode CORDIC, ITERS_PER_STAGE (two) iterations deep.
// Depends on lsw_pkg for the vector type and the arctangent table.
module lsw_cordic_stage #(
  parameter int unsigned FIRST_ITER = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  lsw_pkg::crd_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output lsw_pkg::crd_t data_o,
  input  logic          ready_i
);
  import lsw_pkg::*;

  logic valid_q;
  crd_t data_q;
  crd_t data_d;

  always_comb begin
    crd_t                   cur;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [T_W-1:0]  ang;
    cur = data_i;
    for (int j = 0; j < ITERS_PER_STAGE; j++) begin
      dx  = cur.y >>> (FIRST_ITER + j);
      dy  = cur.x >>> (FIRST_ITER + j);
      ang = $signed(T_W'(ATAN_TAB[FIRST_ITER + j]));
      if (!cur.t[T_W-1]) begin
        cur.x = cur.x - dx;
        cur.y = cur.y + dy;
        cur.t = cur.t - ang;
      end else begin
        cur.x = cur.x + dx;
        cur.y = cur.y - dy;
        cur.t = cur.t + ang;
      end
    end
    data_d = cur;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/lidar_scan_to_world_points.sv =====
// Top level of the lidar scan to world point transform.
// Depends on lsw_pkg, lsw_if, lsw_apb_regs and lsw_cordic_stage.
//
// This block turns lidar range readings into world-frame points. A reading is
// kept when its sample index is a multiple of DECIMATION, it is flagged finite,
// and its range lies between the configured minimum and maximum and is at
// least MIN_RANGE_FLOOR_MM; other readings are consumed and give no output
// transaction. For a kept reading the beam angle is start_angle plus
// sample_index times angle_step plus the robot heading plus a half turn (all
// binary angles, wrapping at a full turn). The range is rotated by that angle
// with a 24-iteration CORDIC, rounded to millimeters, offset by the robot
// position and saturated to 24 bits. The datapath is a 16-stage pipeline:
// one stage for the filter and the two multiplications, one for the angle sum
// and quadrant fold, twelve CORDIC stages of two iterations each, one for
// rounding and one output register for the pose offset and saturation. It
// accepts one reading per clock while no stall holds the pipeline. Every
// stage has its own valid bit and a ready that looks only at the next
// stage, so a stalled sink fills bubbles first and back-pressure reaches
// the input only when the whole pipeline is full. The user must write
// the registers through the APB port only while the stream is idle; the
// block itself does not enforce it. pready is always high and reads return
// the stored value.
module lidar_scan_to_world_points #(
  parameter int unsigned DECIMATION         = 20,
  parameter int unsigned MIN_RANGE_FLOOR_MM = 100
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lsw_in_if.sink                     in_i,
  lsw_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsw_pkg::APB_AW-1:0] paddr,
  input  logic [lsw_pkg::APB_DW-1:0] pwdata,
  output logic [lsw_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import lsw_pkg::*;

  // Divisibility test by multiplication with a reciprocal: for an index below
  // 2^16 and a divisor up to 256, the index is a multiple exactly when the
  // low 32 bits of index times the reciprocal are below 2^16.
  localparam logic [32:0] DivRecip = 33'((64'd1 << 32) / DECIMATION + 64'd1);
  localparam int unsigned DecProdW = IDX_W + 33;
  localparam logic [RANGE_W-1:0] RangeFloor = RANGE_W'(MIN_RANGE_FLOOR_MM);

  cfg_t cfg;

  lsw_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ------------------------------------------------------------------------
  // Stage 1: reading filter, index times angle step, range times CORDIC gain.
  // ------------------------------------------------------------------------
  logic [DecProdW-1:0]        dec_prod;
  logic [IDX_W+ANGLE_W-1:0]   ang_prod;
  logic                       dec_ok;
  logic                       keep;
  logic                       s1_valid_q;
  logic                       s1_ready;
  logic [ANGLE_W-1:0]         s1_angle_q;
  logic [RANGE_W+15:0]        s1_mag_q;
  logic                       s2_ready;

  assign dec_prod = DecProdW'(in_i.sample_index) * DecProdW'(DivRecip);
  assign dec_ok   = (dec_prod[31:16] == '0);
  assign ang_prod = (IDX_W+ANGLE_W)'(in_i.sample_index) * (IDX_W+ANGLE_W)'(cfg.angle_step);

  assign keep = dec_ok && in_i.range_finite
             && (in_i.range_mm >= cfg.min_range_mm)
             && (in_i.range_mm <= cfg.max_range_mm)
             && (in_i.range_mm >= RangeFloor);

  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_i.valid && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_angle_q <= ang_prod[ANGLE_W-1:0];
      s1_mag_q   <= (RANGE_W+16)'(in_i.range_mm) * (RANGE_W+16)'(GAIN_Q16);
    end
  end

  // ------------------------------------------------------------------------
  // Stage 2: full beam angle and fold into the half-plane the CORDIC covers.
  // An angle past a quarter turn either way is moved by a half turn and the
  // start vector is negated instead.
  // ------------------------------------------------------------------------
  logic [ANGLE_W-1:0]     angle_sum;
  logic signed [T_W-1:0]  angle_ext;
  logic signed [XY_W-1:0] mag_ext;
  crd_t                   fold_d;
  logic                   s2_valid_q;
  crd_t                   s2_data_q;

  logic                   crd_valid [CRD_STAGES+1];
  crd_t                   crd_data  [CRD_STAGES+1];
  logic                   crd_ready [CRD_STAGES+1];

  assign angle_sum = s1_angle_q + cfg.angle_base;
  assign angle_ext = $signed({angle_sum[ANGLE_W-1], angle_sum});
  assign mag_ext   = $signed(XY_W'(s1_mag_q));

  always_comb begin
    fold_d.y = '0;
    if (!angle_sum[ANGLE_W-1] && angle_sum[ANGLE_W-2]) begin
      fold_d.t = angle_ext - $signed(T_W'(1) << (ANGLE_W-1));
      fold_d.x = -mag_ext;
    end else if (angle_sum[ANGLE_W-1] && !angle_sum[ANGLE_W-2]) begin
      fold_d.t = angle_ext + $signed(T_W'(1) << (ANGLE_W-1));
      fold_d.x = -mag_ext;
    end else begin
      fold_d.t = angle_ext;
      fold_d.x = mag_ext;
    end
  end

  assign s2_ready = !s2_valid_q || crd_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_data_q <= fold_d;
    end
  end

  // ------------------------------------------------------------------------
  // CORDIC stages, two iterations each.
  // ------------------------------------------------------------------------
  logic rnd_ready;

  assign crd_valid[0]          = s2_valid_q;
  assign crd_data[0]           = s2_data_q;
  assign crd_ready[CRD_STAGES] = rnd_ready;

  for (genvar g = 0; g < CRD_STAGES; g++) begin : g_crd
    lsw_cordic_stage #(
      .FIRST_ITER (g * ITERS_PER_STAGE)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (crd_valid[g]),
      .data_i  (crd_data[g]),
      .ready_o (crd_ready[g]),
      .valid_o (crd_valid[g+1]),
      .data_o  (crd_data[g+1]),
      .ready_i (crd_ready[g+1])
    );
  end

  // ------------------------------------------------------------------------
  // Rounding stage: Q16 vector to millimeters, rounding half up.
  // ------------------------------------------------------------------------
  logic signed [XY_W-1:0]  rx_full;
  logic signed [XY_W-1:0]  ry_full;
  logic                    rnd_valid_q;
  logic signed [RND_W-1:0] rnd_x_q;
  logic signed [RND_W-1:0] rnd_y_q;
  logic                    out_ready;

  assign rx_full = (crd_data[CRD_STAGES].x + $signed(XY_W'(1) << (FRAC_W-1))) >>> FRAC_W;
  assign ry_full = (crd_data[CRD_STAGES].y + $signed(XY_W'(1) << (FRAC_W-1))) >>> FRAC_W;

  assign rnd_ready = !rnd_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
    end else if (rnd_ready) begin
      rnd_valid_q <= crd_valid[CRD_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rnd_ready && crd_valid[CRD_STAGES]) begin
      rnd_x_q <= rx_full[RND_W-1:0];
      rnd_y_q <= ry_full[RND_W-1:0];
    end
  end

  // ------------------------------------------------------------------------
  // Output register: pose offset and saturation to the 24-bit field range.
  // ------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [POS_W-1:0] sat_x;
  logic signed [POS_W-1:0] sat_y;
  logic                    out_valid_q;
  logic signed [POS_W-1:0] out_x_q;
  logic signed [POS_W-1:0] out_y_q;

  function automatic logic signed [POS_W-1:0] sat_pos(logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v[SUM_W-1] != v[SUM_W-2]) begin
      r = v[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  assign sum_x = SUM_W'(rnd_x_q) + SUM_W'(cfg.pose_x_mm);
  assign sum_y = SUM_W'(rnd_y_q) + SUM_W'(cfg.pose_y_mm);
  assign sat_x = sat_pos(sum_x);
  assign sat_y = sat_pos(sum_y);

  assign out_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= rnd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && rnd_valid_q) begin
      out_x_q <= sat_x;
      out_y_q <= sat_y;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.world_x_mm = out_x_q;
  assign out_o.world_y_mm = out_y_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lidar_scan_to_world_points: random and directed readings.
// Depends on lsw_pkg, the lsw_in_if and lsw_out_if interfaces and the block's RTL.

module tb;
  import lsw_pkg::*;

  localparam int unsigned DECIMATION = 20;
  localparam int unsigned RANGE_FLOOR_MM = 100;
  // Sixteen pipeline stages; the drain waits beyond that before the registers change.
  localparam int unsigned PIPE_LATENCY = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned UNMAPPED_REG = 7;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 64;

  localparam longint CORDIC_GAIN_Q16 = 39797;
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam bit [31:0] HALF_TURN = 32'h8000_0000;
  localparam longint WORLD_MAX = 8388607;
  localparam longint WORLD_MIN = -8388608;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
  } point_t;

  typedef struct {
    int unsigned idx;
    bit [31:0]   value;
  } reg_write_t;

  logic clk_i;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lsw_in_if  reading_if ();
  lsw_out_if point_if ();

  lidar_scan_to_world_points #(
    .DECIMATION        (DECIMATION),
    .MIN_RANGE_FLOOR_MM(RANGE_FLOOR_MM)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (reading_if),
    .out_o  (point_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Our own copy of the register file, updated at the edge on which each
  // APB write completes. Readings are predicted against it when accepted.
  bit [31:0]  reg_shadow [7];
  reg_write_t staged_writes [$];
  point_t     pending_points [$];

  // Rotation angles atan(2^-i) as binary angles, a full turn being 2^32.
  longint rot_angle [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  int unsigned mismatch_count = 0;
  int unsigned points_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          idle_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap lengths for both sides: mostly none, often short, rarely long.
  // With idle_on cleared both sides run back to back.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void apply_reg(int unsigned idx, bit [31:0] value);
    case (idx)
      REG_START_ANGLE:  reg_shadow[REG_START_ANGLE] = value;
      REG_ANGLE_STEP:   reg_shadow[REG_ANGLE_STEP] = value;
      REG_MIN_RANGE:    reg_shadow[REG_MIN_RANGE] = {16'h0, value[15:0]};
      REG_MAX_RANGE:    reg_shadow[REG_MAX_RANGE] = {16'h0, value[15:0]};
      REG_POSE_X:       reg_shadow[REG_POSE_X] = {8'h0, value[23:0]};
      REG_POSE_Y:       reg_shadow[REG_POSE_Y] = {8'h0, value[23:0]};
      REG_POSE_HEADING: reg_shadow[REG_POSE_HEADING] = value;
      default: ;  // Writes past the register list have no effect.
    endcase
  endfunction

  function automatic logic signed [23:0] clamp_world(longint v);
    if (v > WORLD_MAX) return 24'sh7F_FFFF;
    if (v < WORLD_MIN) return 24'sh80_0000;
    return v[23:0];
  endfunction

  // Decides whether a reading survives decimation and the range gate and,
  // if it does, rotates it into the world frame exactly as the hardware's
  // 24-step CORDIC does, including the quadrant fold and floor shifts.
  function automatic bit predict_point(input logic [15:0] range_mm, input logic finite,
                                       input logic [15:0] idx, output point_t p);
    bit [31:0] beam_angle;
    longint    t, x, y, dx, dy;
    logic [15:0] min_mm, max_mm;
    min_mm = reg_shadow[REG_MIN_RANGE][15:0];
    max_mm = reg_shadow[REG_MAX_RANGE][15:0];
    p = '0;
    if ((idx % DECIMATION) != 0 || !finite) return 1'b0;
    if (range_mm < min_mm || range_mm > max_mm || range_mm < RANGE_FLOOR_MM) return 1'b0;

    // The beam angle wraps at a full turn; the half turn flips the sensor frame.
    beam_angle = reg_shadow[REG_START_ANGLE] + idx * reg_shadow[REG_ANGLE_STEP]
               + reg_shadow[REG_POSE_HEADING] + HALF_TURN;
    t = longint'($signed(beam_angle));
    x = longint'(range_mm) * CORDIC_GAIN_Q16;
    y = 0;
    // Fold the back half plane onto the front one by negating the vector.
    if (t >= QUARTER_TURN) begin
      t = t - 2 * QUARTER_TURN;
      x = -x;
    end else if (t < -QUARTER_TURN) begin
      t = t + 2 * QUARTER_TURN;
      x = -x;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (t >= 0) begin
        x = x - dx;
        y = y + dy;
        t = t - rot_angle[i];
      end else begin
        x = x + dx;
        y = y - dy;
        t = t + rot_angle[i];
      end
    end
    p.x = clamp_world(((x + 32768) >>> 16) + longint'($signed(reg_shadow[REG_POSE_X][23:0])));
    p.y = clamp_world(((y + 32768) >>> 16) + longint'($signed(reg_shadow[REG_POSE_Y][23:0])));
    return 1'b1;
  endfunction

  function automatic void stage_write(int unsigned idx, bit [31:0] value);
    reg_write_t w;
    w.idx = idx;
    w.value = value;
    staged_writes = {staged_writes, w};
  endfunction

  // Issues the staged register writes back to back over APB and releases
  // the bus after the last one. Called once per configuration phase.
  task automatic commit_writes();
    reg_write_t w;
    while (staged_writes.size() > 0) begin
      w = staged_writes.pop_front();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= APB_AW'(w.idx << 2);
      pwdata <= w.value;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (pready !== 1'b1);
      apply_reg(w.idx, w.value);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sends one reading and, once the transaction is accepted, records the
  // point it should produce. Valid stays high when the next reading follows
  // without a gap.
  task automatic send_reading(input logic [15:0] range_mm, input logic finite,
                              input logic [15:0] idx);
    int unsigned gap;
    point_t      p;
    gap = pick_gap();
    if (gap > 0) begin
      reading_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    reading_if.valid <= 1'b1;
    reading_if.range_mm <= range_mm;
    reading_if.range_finite <= finite;
    reading_if.sample_index <= idx;
    do @(posedge clk_i); while (reading_if.ready !== 1'b1);
    if (predict_point(range_mm, finite, idx, p)) pending_points = {pending_points, p};
  endtask

  // Stops the stream, waits for every pending point, then waits beyond the
  // pipeline depth before the registers change.
  task automatic drain_stream();
    reading_if.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  // Defaults after reset: the beam points along the negative x axis.
  // Covers decimation, the finite flag and the range floor at their edges.
  task automatic test_reset_defaults();
    send_reading(16'd1000, 1'b0, 16'd0);
    send_reading(16'd1000, 1'b1, 16'd19);
    send_reading(16'd0, 1'b1, 16'd0);
    send_reading(16'd99, 1'b1, 16'd20);
    send_reading(16'd100, 1'b1, 16'd40);
    send_reading(16'hFFFF, 1'b1, 16'd0);
    send_reading(16'hFFFF, 1'b1, 16'd65520);
    send_reading(16'hFFFF, 1'b1, 16'hFFFF);
    drain_stream();
  endtask

  // A start angle of a half turn cancels the frame flip, so the heading
  // alone sets the angle. Each heading sits on or just beside a fold edge.
  task automatic test_quadrant_folds();
    bit [31:0] headings [4] = '{32'h4000_0000, 32'h3FFF_FFFF, 32'hC000_0000, 32'hBFFF_FFFF};
    foreach (headings[i]) begin
      stage_write(REG_START_ANGLE, HALF_TURN);
      stage_write(REG_ANGLE_STEP, 32'h0);
      stage_write(REG_POSE_HEADING, headings[i]);
      commit_writes();
      send_reading(16'd12345, 1'b1, 16'd60);
      drain_stream();
    end
  endtask

  // Range gate: an inverted window passes nothing, a one-value window passes
  // exactly that value, and a window reaching below the floor is cut at it.
  task automatic test_range_window();
    stage_write(REG_MIN_RANGE, 32'd5000);
    stage_write(REG_MAX_RANGE, 32'd4000);
    commit_writes();
    send_reading(16'd4500, 1'b1, 16'd0);
    send_reading(16'd5000, 1'b1, 16'd20);
    drain_stream();
    stage_write(REG_MIN_RANGE, 32'd3000);
    stage_write(REG_MAX_RANGE, 32'd3000);
    commit_writes();
    send_reading(16'd3000, 1'b1, 16'd0);
    send_reading(16'd3001, 1'b1, 16'd0);
    drain_stream();
    stage_write(REG_MIN_RANGE, 32'd0);
    stage_write(REG_MAX_RANGE, 32'd150);
    commit_writes();
    send_reading(16'd99, 1'b1, 16'd0);
    send_reading(16'd100, 1'b1, 16'd0);
    send_reading(16'd150, 1'b1, 16'd0);
    drain_stream();
  endtask

  // Poses at the field limits push the world point past both ends.
  task automatic test_saturation();
    stage_write(REG_MAX_RANGE, 32'hFFFF);
    stage_write(REG_POSE_X, 32'h007F_FFFF);
    stage_write(REG_POSE_Y, 32'hFF80_0000);
    stage_write(REG_POSE_HEADING, 32'h0);
    commit_writes();
    send_reading(16'hFFFF, 1'b1, 16'd0);
    drain_stream();
    stage_write(REG_POSE_X, 32'h0080_0000);
    stage_write(REG_POSE_Y, 32'h007F_FFFF);
    stage_write(REG_POSE_HEADING, 32'h8000_0000);
    commit_writes();
    send_reading(16'hFFFF, 1'b1, 16'd0);
    drain_stream();
  endtask

  // A write past the last register must leave every register unchanged.
  task automatic test_unmapped_register();
    stage_write(UNMAPPED_REG, 32'hDEAD_BEEF);
    commit_writes();
    send_reading(16'd2500, 1'b1, 16'd80);
    drain_stream();
  endtask

  // Each phase writes every register. Phases 0 and 1 hold the extremes, phase 2 a
  // random range window; the rest are random with mostly small poses and a sane window.
  task automatic program_random_setup(int unsigned phase);
    bit [15:0] lo, hi;
    bit [31:0] start, step, pose_x, pose_y;
    lo = 16'($urandom_range(0, 3000));
    hi = 16'($urandom_range(lo, 65535));
    start = $urandom;
    step = $urandom;
    pose_x = (($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 10000)) - 32'd5000);
    pose_y = (($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 10000)) - 32'd5000);
    case (phase)
      0: begin
        lo = 16'h0;
        hi = 16'hFFFF;
        start = 32'h7FFF_FFFF;
        step = 32'h7FFF_FFFF;
        pose_x = 32'h007F_FFFF;
        pose_y = 32'h007F_FFFF;
      end
      1: begin
        lo = 16'hFFFF;
        hi = 16'hFFFF;
        start = 32'h8000_0000;
        step = 32'h8000_0000;
        pose_x = 32'hFF80_0000;
        pose_y = 32'hFF80_0000;
      end
      2: begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
      default: ;
    endcase
    stage_write(REG_START_ANGLE, start);
    stage_write(REG_ANGLE_STEP, step);
    stage_write(REG_MIN_RANGE, {16'($urandom_range(0, 65535)), lo});
    stage_write(REG_MAX_RANGE, {16'($urandom_range(0, 65535)), hi});
    stage_write(REG_POSE_X, pose_x);
    stage_write(REG_POSE_Y, pose_y);
    stage_write(REG_POSE_HEADING, $urandom);
    commit_writes();
  endtask

  // Most readings are decimated, finite and inside the window so that the
  // rotation itself gets exercised; the rest are fully random fields.
  task automatic test_random_scans();
    int unsigned lo, hi, roll;
    logic [15:0] range_mm, idx;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_random_setup(phase);
      idle_on = (phase != 5);
      lo = reg_shadow[REG_MIN_RANGE];
      if (lo < RANGE_FLOOR_MM) lo = RANGE_FLOOR_MM;
      hi = reg_shadow[REG_MAX_RANGE];
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 80 && lo <= hi) begin
          idx = 16'(DECIMATION * $urandom_range(0, 65535 / DECIMATION));
          if (roll < 8) range_mm = 16'(lo);
          else if (roll < 16) range_mm = 16'(hi);
          else range_mm = 16'($urandom_range(lo, hi));
          send_reading(range_mm, 1'b1, idx);
        end else begin
          send_reading(16'($urandom), 1'($urandom), 16'($urandom));
        end
      end
      drain_stream();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 7; i++) reg_shadow[i] = 32'h0;
    reg_shadow[REG_MAX_RANGE] = 32'h0000_FFFF;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    reading_if.valid <= 1'b0;
    reading_if.range_mm <= '0;
    reading_if.range_finite <= 1'b0;
    reading_if.sample_index <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_quadrant_folds();
    test_range_window();
    test_saturation();
    test_unmapped_register();
    test_random_scans();
    drain_stream();

    if (mismatch_count == 0) begin
      $display("lidar_scan_to_world_points regression: pass");
    end else begin
      $display("lidar_scan_to_world_points regression: fail");
    end
    $finish;
  end

  // The point sink stalls in runs whose lengths follow the same mix as the
  // gaps on the reading side, so back-pressure hits every pipeline phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      point_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      point_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      int unsigned gap;
      gap = pick_gap();
      point_if.ready <= (gap == 0);
      stall_left <= (gap > 0) ? gap - 1 : 0;
    end
  end

  // Every point transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && point_if.valid === 1'b1 && point_if.ready === 1'b1) begin
      point_t want;
      points_seen++;
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("point %0d arrived with nothing pending: x=%0d y=%0d",
                   points_seen, point_if.world_x_mm, point_if.world_y_mm);
      end else begin
        want = pending_points.pop_front();
        if (point_if.world_x_mm !== want.x) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("point %0d world_x_mm: expected %0d, got %0d",
                     points_seen, want.x, point_if.world_x_mm);
        end
        if (point_if.world_y_mm !== want.y) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("point %0d world_y_mm: expected %0d, got %0d",
                     points_seen, want.y, point_if.world_y_mm);
        end
      end
    end
  end

  // Watchdog: a lost point or a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lidar_scan_to_world_points regression: fail");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/lsw_pkg.sv
rtl/lsw_if.sv
rtl/lsw_apb_regs.sv
rtl/lsw_cordic_stage.sv
rtl/lidar_scan_to_world_points.sv
tb/sv/tb.sv
